// ===== hdl/gprd_pkg.sv =====
// Shared types, constants and helper functions for the gamepad report decoder.
// Used by every module under hdl; depends on nothing else.
`timescale 1ns / 1ps

package gprd_pkg;

	localparam int REPORT_LEN_DEF = 21;
	localparam int KEEP_BYTES     = 6;
	localparam int KEEP_IDX_W     = 3;

	localparam logic [9:0] SCALE_RESET  = 10'd180;
	localparam logic [7:0] SCRAMBLE_KEY = 8'h17;
	localparam logic [7:0] ALL_ONES     = 8'hFF;

	localparam logic [1:0] STATUS_DECODED = 2'd0;
	localparam logic [1:0] STATUS_ABSENT  = 2'd1;
	localparam logic [1:0] STATUS_ORIGIN  = 2'd2;

	// Report byte roles
	localparam int BYTE_LX    = 0;
	localparam int BYTE_LY    = 1;
	localparam int BYTE_RY    = 2;
	localparam int BYTE_KEYHI = 4;
	localparam int BYTE_KEYLO = 5;

	localparam int KEY_UP    = 0;
	localparam int KEY_LEFT  = 1;
	localparam int KEY_DOWN  = 14;
	localparam int KEY_RIGHT = 15;

	typedef struct packed {
		logic [KEEP_BYTES-1:0][7:0] bytes;
		logic                       absent;
	} gprd_report_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [15:0]        keys;
		logic [15:0]        pressed;
		logic [15:0]        released;
		logic signed [6:0]  left_x;
		logic signed [6:0]  left_y;
		logic signed [5:0]  right_x;
		logic signed [5:0]  right_y;
		logic [15:0]        mapped_keys;
	} gprd_fields_t;

	typedef struct packed {
		gprd_fields_t f;
		logic         scale_en;
		logic         neg_x;
		logic         neg_y;
		logic [6:0]   mag_x;
		logic [6:0]   mag_y;
	} gprd_decoded_t;

	typedef struct packed {
		gprd_fields_t       f;
		logic signed [9:0]  scaled_x;
		logic signed [9:0]  scaled_y;
	} gprd_result_t;

	function automatic logic [7:0] unscramble(input logic [7:0] b);
		return (b ^ SCRAMBLE_KEY) + SCRAMBLE_KEY;
	endfunction

	// Move controller button bits to console key positions; two buttons have no slot.
	function automatic logic [15:0] remap(input logic [15:0] k);
		logic [15:0] r;
		r = '0;
		r[6]  = k[0];
		r[5]  = k[1];
		r[15] = k[2];
		r[10] = k[3];
		r[0]  = k[4];
		r[11] = k[5];
		r[1]  = k[6];
		r[14] = k[7];
		r[8]  = k[9];
		r[3]  = k[10];
		r[2]  = k[12];
		r[9]  = k[13];
		r[7]  = k[14];
		r[4]  = k[15];
		return r;
	endfunction

endpackage

// ===== hdl/gprd_capture.sv =====
// Byte capture: counts report bytes, keeps the leading bytes, tracks the all-0xFF
// case and registers one report snapshot per report end. Depends on gprd_pkg.
`timescale 1ns / 1ps

module gprd_capture import gprd_pkg::*; #(
	parameter int REPORT_LEN = REPORT_LEN_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,
	input  logic         s_axis_tlast,
	output logic         rpt_valid,
	input  logic         rpt_ready,
	output gprd_report_t rpt
);

	localparam int POS_W = $clog2(REPORT_LEN);

	logic [POS_W-1:0] pos_q;
	logic             all_ones_q;
	logic [7:0]       kept_q [KEEP_BYTES];
	logic             rpt_valid_s1;
	gprd_report_t     rpt_s1;
	gprd_report_t     snap;
	logic             accept;
	logic             report_end;
	logic             byte_ones;

	assign s_axis_tready = !rpt_valid_s1 || rpt_ready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign report_end    = s_axis_tlast || (pos_q == POS_W'(REPORT_LEN - 1));
	assign byte_ones     = (s_axis_tdata == ALL_ONES);

	// Merge the byte in transfer with what is already kept
	always_comb begin
		for (int i = 0; i < KEEP_BYTES; i++) begin
			snap.bytes[i] = (pos_q == POS_W'(i)) ? s_axis_tdata : kept_q[i];
		end
		snap.absent = all_ones_q && byte_ones;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			all_ones_q   <= 1'b1;
			rpt_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				pos_q      <= report_end ? '0 : pos_q + 1'b1;
				all_ones_q <= report_end ? 1'b1 : (all_ones_q && byte_ones);
			end
			if (accept && report_end) begin
				rpt_valid_s1 <= 1'b1;
			end else if (rpt_ready) begin
				rpt_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (pos_q < POS_W'(KEEP_BYTES))) begin
			kept_q[pos_q[KEEP_IDX_W-1:0]] <= s_axis_tdata;
		end
		if (accept && report_end) begin
			rpt_s1 <= snap;
		end
	end

	assign rpt_valid = rpt_valid_s1;
	assign rpt       = rpt_s1;

endmodule

// ===== hdl/gprd_decode.sv =====
// Report decode: buttons, edges against the previous report, stick deltas and
// origin capture, registered into stage two. Depends on gprd_pkg.
`timescale 1ns / 1ps

module gprd_decode import gprd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rpt_valid,
	output logic          rpt_ready,
	input  gprd_report_t  rpt,
	output logic          dec_valid,
	input  logic          dec_ready,
	output gprd_decoded_t dec
);

	logic [15:0]   prev_keys_q;
	logic [5:0]    lx_org_q;
	logic [5:0]    ly_org_q;
	logic [4:0]    rx_org_q;
	logic [4:0]    ry_org_q;
	logic          calibrated_q;
	logic          dec_valid_s2;
	gprd_decoded_t dec_s2;
	gprd_decoded_t nxt;
	logic          take;
	logic [7:0]    d0, d1, d2;
	logic [15:0]   keys_raw;
	logic [15:0]   keys;
	logic [5:0]    lx, ly;
	logic [4:0]    rx, ry;
	logic [7:0]    ax, ay;

	assign rpt_ready = !dec_valid_s2 || dec_ready;
	assign take      = rpt_valid && rpt_ready;

	always_comb begin
		d0       = unscramble(rpt.bytes[BYTE_LX]);
		d1       = unscramble(rpt.bytes[BYTE_LY]);
		d2       = unscramble(rpt.bytes[BYTE_RY]);
		keys_raw = ~{unscramble(rpt.bytes[BYTE_KEYHI]), unscramble(rpt.bytes[BYTE_KEYLO])};
		keys     = keys_raw;
		// Up masks down, left masks right
		keys[KEY_DOWN]  = keys_raw[KEY_DOWN] && !keys_raw[KEY_UP];
		keys[KEY_RIGHT] = keys_raw[KEY_RIGHT] && !keys_raw[KEY_LEFT];

		lx = d0[5:0];
		ly = d1[5:0];
		rx = {d0[7:6], d1[7:6], d2[7]};
		ry = d2[4:0];

		// Offset by 32 ahead of scaling; keep sign and magnitude
		ax = {2'b00, lx} + 8'd32 - {2'b00, lx_org_q};
		ay = {2'b00, ly} + 8'd32 - {2'b00, ly_org_q};

		nxt = '0;
		if (rpt.absent) begin
			nxt.f.status = STATUS_ABSENT;
		end else begin
			nxt.f.keys     = keys;
			nxt.f.pressed  = keys & ~prev_keys_q;
			nxt.f.released = ~keys & prev_keys_q;
			if (!calibrated_q) begin
				nxt.f.status = STATUS_ORIGIN;
			end else begin
				nxt.f.status      = STATUS_DECODED;
				nxt.f.left_x      = $signed({1'b0, lx}) - $signed({1'b0, lx_org_q});
				nxt.f.left_y      = $signed({1'b0, ly}) - $signed({1'b0, ly_org_q});
				nxt.f.right_x     = $signed({1'b0, rx}) - $signed({1'b0, rx_org_q});
				nxt.f.right_y     = $signed({1'b0, ry}) - $signed({1'b0, ry_org_q});
				nxt.f.mapped_keys = remap(keys);
				nxt.scale_en      = 1'b1;
				nxt.neg_x         = ax[7];
				nxt.neg_y         = ay[7];
				nxt.mag_x         = ax[7] ? 7'(-ax) : ax[6:0];
				nxt.mag_y         = ay[7] ? 7'(-ay) : ay[6:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_keys_q  <= '0;
			lx_org_q     <= '0;
			ly_org_q     <= '0;
			rx_org_q     <= '0;
			ry_org_q     <= '0;
			calibrated_q <= 1'b0;
			dec_valid_s2 <= 1'b0;
		end else begin
			if (take && !rpt.absent) begin
				prev_keys_q <= keys;
				if (!calibrated_q) begin
					lx_org_q     <= lx;
					ly_org_q     <= ly;
					rx_org_q     <= rx;
					ry_org_q     <= ry;
					calibrated_q <= 1'b1;
				end
			end
			if (take) begin
				dec_valid_s2 <= 1'b1;
			end else if (dec_ready) begin
				dec_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dec_s2 <= nxt;
		end
	end

	assign dec_valid = dec_valid_s2;
	assign dec       = dec_s2;

endmodule

// ===== hdl/gprd_scale.sv =====
// Left stick scaling: multiply by twice the scale, divide by 63 toward zero,
// subtract the scale, saturate; ends in the result register. Depends on gprd_pkg.
`timescale 1ns / 1ps

module gprd_scale import gprd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [9:0]    stick_scale,
	input  logic          dec_valid,
	output logic          dec_ready,
	input  gprd_decoded_t dec,
	output logic          res_valid,
	input  logic          res_ready,
	output gprd_result_t  res
);

	// Finish one axis: correct the reciprocal estimate, apply sign, offset, clamp
	function automatic logic signed [9:0] finish(input logic [17:0] prod,
		input logic [12:0] q0, input logic neg, input logic [9:0] s);
		logic [18:0]        r;
		logic [11:0]        q;
		logic signed [13:0] v;
		logic signed [13:0] t;
		logic signed [9:0]  o;
		r = {1'b0, prod} - {q0, 6'd0} + {6'd0, q0};
		q = q0[11:0] + ((r >= 19'd63) ? 12'd1 : 12'd0);
		v = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
		t = v - $signed({4'd0, s});
		if (t > 14'sd511) begin
			o = 10'sd511;
		end else if (t < -14'sd512) begin
			o = -10'sd512;
		end else begin
			o = t[9:0];
		end
		return o;
	endfunction

	logic          valid_s3, valid_s4, res_valid_q;
	gprd_fields_t  f_s3, f_s4;
	logic          en_s3, en_s4;
	logic          neg_x_s3, neg_y_s3, neg_x_s4, neg_y_s4;
	logic [17:0]   prod_x_s3, prod_y_s3, prod_x_s4, prod_y_s4;
	logic [12:0]   q0_x_s4, q0_y_s4;
	gprd_result_t  res_q;
	logic          out_adv, s4_adv, s3_adv;
	logic [17:0]   prod_x, prod_y;
	logic [28:0]   est_x, est_y;
	gprd_result_t  res_nxt;

	assign out_adv   = !res_valid_q || res_ready;
	assign s4_adv    = !valid_s4 || out_adv;
	assign s3_adv    = !valid_s3 || s4_adv;
	assign dec_ready = s3_adv;

	assign prod_x = {11'd0, dec.mag_x} * {7'd0, stick_scale, 1'b0};
	assign prod_y = {11'd0, dec.mag_y} * {7'd0, stick_scale, 1'b0};

	// m * 1040 / 65536 undershoots m / 63 by less than one
	assign est_x = {1'b0, prod_x_s3, 10'd0} + {7'd0, prod_x_s3, 4'd0};
	assign est_y = {1'b0, prod_y_s3, 10'd0} + {7'd0, prod_y_s3, 4'd0};

	always_comb begin
		res_nxt.f = f_s4;
		if (en_s4) begin
			res_nxt.scaled_x = finish(prod_x_s4, q0_x_s4, neg_x_s4, stick_scale);
			res_nxt.scaled_y = finish(prod_y_s4, q0_y_s4, neg_y_s4, stick_scale);
		end else begin
			res_nxt.scaled_x = '0;
			res_nxt.scaled_y = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s3_adv) begin
				valid_s3 <= dec_valid;
			end
			if (s4_adv) begin
				valid_s4 <= valid_s3;
			end
			if (out_adv) begin
				res_valid_q <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s3_adv && dec_valid) begin
			f_s3      <= dec.f;
			en_s3     <= dec.scale_en;
			neg_x_s3  <= dec.neg_x;
			neg_y_s3  <= dec.neg_y;
			prod_x_s3 <= prod_x;
			prod_y_s3 <= prod_y;
		end
		if (s4_adv && valid_s3) begin
			f_s4      <= f_s3;
			en_s4     <= en_s3;
			neg_x_s4  <= neg_x_s3;
			neg_y_s4  <= neg_y_s3;
			prod_x_s4 <= prod_x_s3;
			prod_y_s4 <= prod_y_s3;
			q0_x_s4   <= est_x[28:16];
			q0_y_s4   <= est_y[28:16];
		end
		if (out_adv && valid_s4) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== hdl/gamepad_report_decoder_top.sv =====
// Gamepad report decoder: one report byte per cycle in, one result per report out.
// Path: a report's snapshot passes the capture, decode, scale s3, scale s4 and result registers in turn.
// Throughput: one byte per cycle; the input stalls only once all five result stages are full.
// Reset: arst_n clears counters, origins, previous buttons, calibration and valids;
// stick_scale returns to 180. Depends on gprd_pkg and the gprd_* modules.
`timescale 1ns / 1ps

module gamepad_report_decoder_top import gprd_pkg::*; #(
	parameter int REPORT_LEN = REPORT_LEN_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [9:0]   cfg_wdata,      // stick_scale
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // report_byte
	input  logic         s_axis_tlast,   // last_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// keys[15:0] pressed[31:16] released[47:32] left_x[54:48] left_y[61:55]
	// right_x[67:62] right_y[73:68] mapped_keys[89:74] scaled_x[99:90]
	// scaled_y[109:100], zero[111:110]
	output logic [111:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser    // status
);

	logic          [9:0] stick_scale_q;
	logic                rpt_valid, rpt_ready;
	gprd_report_t        rpt;
	logic                dec_valid, dec_ready;
	gprd_decoded_t       dec;
	gprd_result_t        res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			stick_scale_q <= cfg_wdata;
		end
	end

	gprd_capture #(
		.REPORT_LEN(REPORT_LEN)
	) u_capture (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.rpt_valid    (rpt_valid),
		.rpt_ready    (rpt_ready),
		.rpt          (rpt)
	);

	gprd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.rpt_valid(rpt_valid),
		.rpt_ready(rpt_ready),
		.rpt      (rpt),
		.dec_valid(dec_valid),
		.dec_ready(dec_ready),
		.dec      (dec)
	);

	gprd_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.stick_scale(stick_scale_q),
		.dec_valid  (dec_valid),
		.dec_ready  (dec_ready),
		.dec        (dec),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res        (res)
	);

	assign m_axis_tuser = res.f.status;
	assign m_axis_tdata = {2'b00, res.scaled_y, res.scaled_x, res.f.mapped_keys,
		res.f.right_y, res.f.right_x, res.f.left_y, res.f.left_x,
		res.f.released, res.f.pressed, res.f.keys};

endmodule
